>>> rtl/i2c_register_access_master_defines.svh
// Assertion macros for the I2C register access master.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/i2cram_pkg.sv
// Shared types and constants for the I2C register access master.
// No dependencies; used by every module of the block.
package i2cram_pkg;

   localparam int unsigned DEV_ADDR_W   = 7;
   localparam int unsigned TICKS_W      = 16;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'd42;
   localparam logic [TICKS_W-1:0]    HALF_PERIOD_RESET = 16'd250;
   localparam logic [TICKS_W-1:0]    ACK_TIMEOUT_RESET = 16'd250;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEV_ADDR    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 2'd2;

   // request mode codes
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  target_reg;
      logic [15:0] write_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        ack_fail;
   } rsp_type;

   // one classified tick word as held in the queue
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  target_reg;
      logic [15:0] write_data;
      logic        sda_in;
   } tick_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [DEV_ADDR_W-1:0] dev_addr;
      logic [TICKS_W-1:0]    half_period;
      logic [TICKS_W-1:0]    ack_timeout;
   } cfg_type;

   typedef enum logic [16:0] {
      PH_IDLE    = 17'h00001,
      PH_RS      = 17'h00002,
      PH_ST_A    = 17'h00004,
      PH_ST_B    = 17'h00008,
      PH_ST_C    = 17'h00010,
      PH_TX_LOW  = 17'h00020,
      PH_TX_HIGH = 17'h00040,
      PH_AK_LOW  = 17'h00080,
      PH_AK_WAIT = 17'h00100,
      PH_AK_HOLD = 17'h00200,
      PH_RX_LOW  = 17'h00400,
      PH_RX_HIGH = 17'h00800,
      PH_MA_LOW  = 17'h01000,
      PH_MA_HIGH = 17'h02000,
      PH_SP_A    = 17'h04000,
      PH_SP_B    = 17'h08000,
      PH_SP_C    = 17'h10000
   } phase_type;

endpackage

>>> rtl/i2cram_front.sv
// Front end: takes request words, classifies the command and pushes into the queue.
// Depends on i2cram_pkg.
module i2cram_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  i2cram_pkg::req_type     req_payload,
   input  i2cram_pkg::q_status_type q_status,
   output logic                    push,
   output i2cram_pkg::tick_type    push_data
);

   i2cram_pkg::cmd_type cmd;

   always_comb begin
      unique case (req_payload.mode)
         i2cram_pkg::MODE_WRITE: cmd = i2cram_pkg::CMD_WRITE;
         i2cram_pkg::MODE_READ:  cmd = i2cram_pkg::CMD_READ;
         default:                cmd = i2cram_pkg::CMD_NONE;
      endcase
   end

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   assign push_data.cmd        = cmd;
   assign push_data.target_reg = req_payload.target_reg;
   assign push_data.write_data = req_payload.write_data;
   assign push_data.sda_in     = req_payload.sda_in;

endmodule

>>> rtl/i2cram_queue.sv
// Short FIFO of classified tick words between front end and bus engine.
// Depends on i2cram_pkg.
module i2cram_queue #(
   parameter int unsigned DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  i2cram_pkg::tick_type     push_data,
   input  logic                     pop,
   output i2cram_pkg::tick_type     pop_data,
   output i2cram_pkg::q_status_type q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   i2cram_pkg::tick_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = store_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

endmodule

>>> rtl/i2cram_engine.sv
// Bus engine: steps the I2C sequencer once per tick word and registers the result.
// Depends on i2cram_pkg.
module i2cram_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cram_pkg::cfg_type      cfg,
   input  i2cram_pkg::q_status_type q_status,
   input  i2cram_pkg::tick_type     tick,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2cram_pkg::rsp_type      rsp_payload
);

   localparam int unsigned TW = i2cram_pkg::TICKS_W;

   i2cram_pkg::phase_type phase_ff, phase_in;
   logic [3:0]    bit_ff, bit_in;
   logic [TW-1:0] delay_ff, delay_in;
   logic [TW-1:0] wait_ff, wait_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    held_reg_ff, held_reg_in;
   logic [15:0]   held_data_ff, held_data_in;
   logic [15:0]   read_value_ff, read_value_in;
   logic          is_read_ff, is_read_in;
   logic          failed_ff, failed_in;
   logic [2:0]    byte_no_ff, byte_no_in;
   logic          rsp_valid_ff;
   i2cram_pkg::rsp_type rsp_ff, rsp_in;

   logic [TW-1:0] half_eff;
   logic [TW:0]   delay_inc;
   logic [TW:0]   wait_inc;
   logic          over;
   logic          timed;
   logic          done;
   logic [3:0]    bit_inc;
   logic [2:0]    byte_no_inc;
   logic [7:0]    tx_shift;
   logic [7:0]    rx_shift;
   logic [7:0]    addr_wr;
   logic [7:0]    addr_rd;
   logic [1:0]    bus;

   function automatic logic [1:0] bus_drive(i2cram_pkg::phase_type ph, logic b, logic a);
      logic [1:0] d;
      unique case (ph)
         i2cram_pkg::PH_RS:      d = 2'b01;
         i2cram_pkg::PH_ST_B:    d = 2'b10;
         i2cram_pkg::PH_ST_C:    d = 2'b00;
         i2cram_pkg::PH_TX_LOW:  d = {1'b0, b};
         i2cram_pkg::PH_TX_HIGH: d = {1'b1, b};
         i2cram_pkg::PH_AK_LOW:  d = 2'b01;
         i2cram_pkg::PH_RX_LOW:  d = 2'b01;
         i2cram_pkg::PH_MA_LOW:  d = {1'b0, a};
         i2cram_pkg::PH_MA_HIGH: d = {1'b1, a};
         i2cram_pkg::PH_SP_A:    d = 2'b00;
         i2cram_pkg::PH_SP_B:    d = 2'b10;
         default:                d = 2'b11;
      endcase
      return d;
   endfunction

   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   // a zero half period still lasts one tick
   assign half_eff    = (cfg.half_period == '0) ? TW'(1) : cfg.half_period;
   assign delay_inc   = {1'b0, delay_ff} + (TW+1)'(1);
   assign wait_inc    = {1'b0, wait_ff} + (TW+1)'(1);
   assign over        = (delay_inc >= {1'b0, half_eff});
   assign bit_inc     = bit_ff + 4'd1;
   assign byte_no_inc = byte_no_ff + 3'd1;
   assign tx_shift    = {shift_ff[6:0], 1'b0};
   assign rx_shift    = {shift_ff[6:0], tick.sda_in};
   assign addr_wr     = {cfg.dev_addr, 1'b0};
   assign addr_rd     = {cfg.dev_addr, 1'b1};

   always_comb begin
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      wait_in       = wait_ff;
      shift_in      = shift_ff;
      held_reg_in   = held_reg_ff;
      held_data_in  = held_data_ff;
      read_value_in = read_value_ff;
      is_read_in    = is_read_ff;
      failed_in     = failed_ff;
      byte_no_in    = byte_no_ff;
      done          = 1'b0;
      timed         = 1'b1;
      unique case (phase_ff)
         i2cram_pkg::PH_IDLE: begin
            timed = 1'b0;
            if (tick.cmd != i2cram_pkg::CMD_NONE) begin
               held_reg_in   = tick.target_reg;
               held_data_in  = tick.write_data;
               is_read_in    = (tick.cmd == i2cram_pkg::CMD_READ);
               failed_in     = 1'b0;
               read_value_in = '0;
               byte_no_in    = '0;
               shift_in      = addr_wr;
               bit_in        = '0;
               phase_in      = i2cram_pkg::PH_ST_A;
            end
         end
         i2cram_pkg::PH_RS: begin
            if (over) phase_in = i2cram_pkg::PH_ST_A;
         end
         i2cram_pkg::PH_ST_A: begin
            if (over) phase_in = i2cram_pkg::PH_ST_B;
         end
         i2cram_pkg::PH_ST_B: begin
            if (over) phase_in = i2cram_pkg::PH_ST_C;
         end
         i2cram_pkg::PH_ST_C: begin
            if (over) begin
               // after a repeated start the address goes out with the read bit
               shift_in = (byte_no_ff == 3'd2) ? addr_rd : addr_wr;
               bit_in   = '0;
               phase_in = i2cram_pkg::PH_TX_LOW;
            end
         end
         i2cram_pkg::PH_TX_LOW: begin
            if (over) phase_in = i2cram_pkg::PH_TX_HIGH;
         end
         i2cram_pkg::PH_TX_HIGH: begin
            if (over) begin
               shift_in = tx_shift;
               bit_in   = bit_inc;
               phase_in = (bit_inc >= 4'd8) ? i2cram_pkg::PH_AK_LOW : i2cram_pkg::PH_TX_LOW;
            end
         end
         i2cram_pkg::PH_AK_LOW: begin
            if (over) begin
               wait_in  = '0;
               phase_in = i2cram_pkg::PH_AK_WAIT;
            end
         end
         i2cram_pkg::PH_AK_WAIT: begin
            timed = 1'b0;
            if (!tick.sda_in) begin
               phase_in = i2cram_pkg::PH_AK_HOLD;
            end else if (wait_inc > {1'b0, cfg.ack_timeout}) begin
               failed_in = 1'b1;
               phase_in  = i2cram_pkg::PH_SP_A;
            end else begin
               wait_in = wait_inc[TW-1:0];
            end
         end
         i2cram_pkg::PH_AK_HOLD: begin
            if (over) begin
               byte_no_in = byte_no_inc;
               if (!is_read_ff) begin
                  unique case (byte_no_inc)
                     3'd1: begin
                        shift_in = held_reg_ff;
                        bit_in   = '0;
                        phase_in = i2cram_pkg::PH_TX_LOW;
                     end
                     3'd2: begin
                        shift_in = held_data_ff[15:8];
                        bit_in   = '0;
                        phase_in = i2cram_pkg::PH_TX_LOW;
                     end
                     3'd3: begin
                        shift_in = held_data_ff[7:0];
                        bit_in   = '0;
                        phase_in = i2cram_pkg::PH_TX_LOW;
                     end
                     default: phase_in = i2cram_pkg::PH_SP_A;
                  endcase
               end else begin
                  unique case (byte_no_inc)
                     3'd1: begin
                        shift_in = held_reg_ff;
                        bit_in   = '0;
                        phase_in = i2cram_pkg::PH_TX_LOW;
                     end
                     3'd2: phase_in = i2cram_pkg::PH_RS;
                     default: begin
                        byte_no_in = 3'd3;
                        shift_in   = '0;
                        bit_in     = '0;
                        phase_in   = i2cram_pkg::PH_RX_LOW;
                     end
                  endcase
               end
            end
         end
         i2cram_pkg::PH_RX_LOW: begin
            if (over) phase_in = i2cram_pkg::PH_RX_HIGH;
         end
         i2cram_pkg::PH_RX_HIGH: begin
            if (over) begin
               shift_in = rx_shift;
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  read_value_in = (byte_no_ff == 3'd3) ? {rx_shift, 8'h00}
                                                       : {read_value_ff[15:8], rx_shift};
                  phase_in = i2cram_pkg::PH_MA_LOW;
               end else begin
                  phase_in = i2cram_pkg::PH_RX_LOW;
               end
            end
         end
         i2cram_pkg::PH_MA_LOW: begin
            if (over) phase_in = i2cram_pkg::PH_MA_HIGH;
         end
         i2cram_pkg::PH_MA_HIGH: begin
            if (over) begin
               if (byte_no_ff == 3'd3) begin
                  byte_no_in = 3'd4;
                  shift_in   = '0;
                  bit_in     = '0;
                  phase_in   = i2cram_pkg::PH_RX_LOW;
               end else begin
                  phase_in = i2cram_pkg::PH_SP_A;
               end
            end
         end
         i2cram_pkg::PH_SP_A: begin
            if (over) phase_in = i2cram_pkg::PH_SP_B;
         end
         i2cram_pkg::PH_SP_B: begin
            if (over) phase_in = i2cram_pkg::PH_SP_C;
         end
         i2cram_pkg::PH_SP_C: begin
            if (over) begin
               phase_in = i2cram_pkg::PH_IDLE;
               done     = 1'b1;
            end
         end
         default: begin
            timed    = 1'b0;
            phase_in = i2cram_pkg::PH_IDLE;
         end
      endcase
   end

   // every phase change and every completed step restarts the delay count
   assign delay_in = (timed && !over) ? delay_inc[TW-1:0] : '0;

   // ack the first read byte, nack the last
   assign bus = bus_drive(phase_in, shift_in[7], byte_no_in != 3'd3);

   always_comb begin
      rsp_in.scl_out   = bus[1];
      rsp_in.sda_out   = bus[0];
      rsp_in.busy_res  = (phase_in != i2cram_pkg::PH_IDLE);
      rsp_in.done_res  = done;
      rsp_in.read_data = done ? read_value_in : '0;
      rsp_in.ack_fail  = done && failed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cram_pkg::PH_IDLE;
         bit_ff       <= '0;
         delay_ff     <= '0;
         wait_ff      <= '0;
         is_read_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         byte_no_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            bit_ff     <= bit_in;
            delay_ff   <= delay_in;
            wait_ff    <= wait_in;
            is_read_ff <= is_read_in;
            failed_ff  <= failed_in;
            byte_no_ff <= byte_no_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         shift_ff      <= shift_in;
         held_reg_ff   <= held_reg_in;
         held_data_ff  <= held_data_in;
         read_value_ff <= read_value_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/i2c_register_access_master.sv
// Top level of the I2C 16-bit register access master: config registers and wiring.
// Depends on i2cram_pkg, i2cram_front, i2cram_queue, i2cram_engine and the defines header.
//
//   channel   direction   handshake               word
//   req_      in          req_valid / req_ready   req_payload (one bus tick)
//   rsp_      out         rsp_valid / rsp_ready   rsp_payload (bus drive and status)
//   csr_      in          csr_write_en            csr_index, csr_wdata
//
// One tick word is taken per cycle while the queue is not full; its result is registered
// in the engine's output register after the word has passed through the tick queue.
// A stalled rsp_ channel fills the queue, then drops req_ready.
// Reset is synchronous: the queue empties, the sequencer returns to idle and the
// configuration registers take their defaults.
`include "i2c_register_access_master_defines.svh"

module i2c_register_access_master #(
   parameter int unsigned QUEUE_DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  i2cram_pkg::req_type                  req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output i2cram_pkg::rsp_type                  rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [i2cram_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cram_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   i2cram_pkg::cfg_type      cfg_ff, cfg_in;
   i2cram_pkg::q_status_type q_status;
   i2cram_pkg::tick_type     push_data;
   i2cram_pkg::tick_type     pop_data;
   logic                     push;
   logic                     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            i2cram_pkg::CSR_DEV_ADDR:
               cfg_in.dev_addr = csr_wdata[i2cram_pkg::DEV_ADDR_W-1:0];
            i2cram_pkg::CSR_HALF_PERIOD:
               cfg_in.half_period = csr_wdata[i2cram_pkg::TICKS_W-1:0];
            i2cram_pkg::CSR_ACK_TIMEOUT:
               cfg_in.ack_timeout = csr_wdata[i2cram_pkg::TICKS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dev_addr    <= i2cram_pkg::DEV_ADDR_RESET;
         cfg_ff.half_period <= i2cram_pkg::HALF_PERIOD_RESET;
         cfg_ff.ack_timeout <= i2cram_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cram_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   i2cram_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   i2cram_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .tick        (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no result appears without a word in flight
   `ASSERT_NEXT(a_no_phantom_word, clock, reset, q_status.empty && !rsp_valid, !rsp_valid)

   // a queued word reaches the output as soon as the output register is free
   `ASSERT_NEXT(a_queue_drains, clock, reset, !q_status.empty && (!rsp_valid || rsp_ready), rsp_valid)

   // the ending tick never reports busy
   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_valid && rsp_payload.done_res, !rsp_payload.busy_res)

endmodule

>>> verif/i2c_register_access_master_tb.sv
// Self-checking bench for the I2C 16-bit register access master, one bus tick per word.
// Depends on i2cram_pkg and the i2c_register_access_master top level; nothing else.
`timescale 1ns / 100ps

module i2c_register_access_master_tb;
   import i2cram_pkg::*;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_payload  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   i2c_register_access_master u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Bus master predictor: own copy of configuration and sequencer state
   // ---------------------------------------------------------------------------------
   logic [6:0]  cfg_dev;
   logic [15:0] cfg_half;
   logic [15:0] cfg_ack_limit;

   phase_type   ph;
   logic [3:0]  bits_done;
   logic [15:0] step_ticks;
   logic [15:0] ack_waited;
   logic [7:0]  shifter;
   logic [7:0]  reg_held;
   logic [15:0] data_held;
   logic [15:0] rx_value;
   logic        reading;
   logic        timed_out;
   logic [2:0]  byte_idx;

   rsp_type bus_drive_due[$];
   req_type bus_ticks_to_send[$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   task automatic clear_bus_model();
      cfg_dev       = DEV_ADDR_RESET;
      cfg_half      = HALF_PERIOD_RESET;
      cfg_ack_limit = ACK_TIMEOUT_RESET;
      ph            = PH_IDLE;
      bits_done     = '0;
      step_ticks    = '0;
      ack_waited    = '0;
      shifter       = '0;
      reg_held      = '0;
      data_held     = '0;
      rx_value      = '0;
      reading       = 1'b0;
      timed_out     = 1'b0;
      byte_idx      = '0;
   endtask

   function void enter(phase_type p);
      ph         = p;
      step_ticks = '0;
   endfunction

   // true once the current timed step has run its full length; zero counts as one
   function bit step_done();
      logic [16:0] hp;
      logic [16:0] n;
      hp = (cfg_half == '0) ? 17'd1 : {1'b0, cfg_half};
      n  = {1'b0, step_ticks} + 17'd1;
      if (n >= hp) begin
         step_ticks = '0;
         return 1'b1;
      end
      step_ticks = n[15:0];
      return 1'b0;
   endfunction

   function void load_tx(logic [7:0] b);
      shifter   = b;
      bits_done = '0;
      enter(PH_TX_LOW);
   endfunction

   function void after_ack_byte();
      byte_idx = byte_idx + 3'd1;
      if (!reading) begin
         case (byte_idx)
            3'd1: load_tx(reg_held);
            3'd2: load_tx(data_held[15:8]);
            3'd3: load_tx(data_held[7:0]);
            default: enter(PH_SP_A);
         endcase
      end else if (byte_idx == 3'd1) begin
         load_tx(reg_held);
      end else if (byte_idx == 3'd2) begin
         enter(PH_RS);
      end else begin
         byte_idx  = 3'd3;
         shifter   = '0;
         bits_done = '0;
         enter(PH_RX_LOW);
      end
   endfunction

   function rsp_type advance_bus_master(req_type t);
      logic [16:0] waited;
      logic        finished;
      logic        master_ack;
      rsp_type     r;
      finished = 1'b0;
      case (ph)
         PH_IDLE: begin
            if (t.mode == MODE_WRITE || t.mode == MODE_READ) begin
               reg_held  = t.target_reg;
               data_held = t.write_data;
               reading   = (t.mode == MODE_READ);
               timed_out = 1'b0;
               rx_value  = '0;
               byte_idx  = '0;
               shifter   = {cfg_dev, 1'b0};
               bits_done = '0;
               enter(PH_ST_A);
            end
         end
         PH_RS:   if (step_done()) enter(PH_ST_A);
         PH_ST_A: if (step_done()) enter(PH_ST_B);
         PH_ST_B: if (step_done()) enter(PH_ST_C);
         PH_ST_C: begin
            // the address byte after a repeated start carries the read bit
            if (step_done()) load_tx({cfg_dev, byte_idx == 3'd2});
         end
         PH_TX_LOW: if (step_done()) enter(PH_TX_HIGH);
         PH_TX_HIGH: begin
            if (step_done()) begin
               shifter   = {shifter[6:0], 1'b0};
               bits_done = bits_done + 4'd1;
               enter(bits_done >= 4'd8 ? PH_AK_LOW : PH_TX_LOW);
            end
         end
         PH_AK_LOW: begin
            if (step_done()) begin
               ack_waited = '0;
               enter(PH_AK_WAIT);
            end
         end
         PH_AK_WAIT: begin
            if (!t.sda_in) begin
               enter(PH_AK_HOLD);
            end else begin
               waited = {1'b0, ack_waited} + 17'd1;
               if (waited > {1'b0, cfg_ack_limit}) begin
                  timed_out = 1'b1;
                  enter(PH_SP_A);
               end else begin
                  ack_waited = waited[15:0];
               end
            end
         end
         PH_AK_HOLD: if (step_done()) after_ack_byte();
         PH_RX_LOW:  if (step_done()) enter(PH_RX_HIGH);
         PH_RX_HIGH: begin
            if (step_done()) begin
               shifter   = {shifter[6:0], t.sda_in};
               bits_done = bits_done + 4'd1;
               if (bits_done >= 4'd8) begin
                  if (byte_idx == 3'd3) rx_value = {shifter, 8'h00};
                  else rx_value = {rx_value[15:8], shifter};
                  enter(PH_MA_LOW);
               end else begin
                  enter(PH_RX_LOW);
               end
            end
         end
         PH_MA_LOW: if (step_done()) enter(PH_MA_HIGH);
         PH_MA_HIGH: begin
            if (step_done()) begin
               if (byte_idx == 3'd3) begin
                  byte_idx  = 3'd4;
                  shifter   = '0;
                  bits_done = '0;
                  enter(PH_RX_LOW);
               end else begin
                  enter(PH_SP_A);
               end
            end
         end
         PH_SP_A: if (step_done()) enter(PH_SP_B);
         PH_SP_B: if (step_done()) enter(PH_SP_C);
         PH_SP_C: begin
            if (step_done()) begin
               enter(PH_IDLE);
               finished = 1'b1;
            end
         end
         default: enter(PH_IDLE);
      endcase

      // acknowledge the first read byte, leave the last one unacknowledged
      master_ack = (byte_idx == 3'd3) ? 1'b0 : 1'b1;
      r = '0;
      case (ph)
         PH_RS:      begin r.scl_out = 1'b0; r.sda_out = 1'b1;       end
         PH_ST_B:    begin r.scl_out = 1'b1; r.sda_out = 1'b0;       end
         PH_ST_C:    begin r.scl_out = 1'b0; r.sda_out = 1'b0;       end
         PH_TX_LOW:  begin r.scl_out = 1'b0; r.sda_out = shifter[7]; end
         PH_TX_HIGH: begin r.scl_out = 1'b1; r.sda_out = shifter[7]; end
         PH_AK_LOW:  begin r.scl_out = 1'b0; r.sda_out = 1'b1;       end
         PH_RX_LOW:  begin r.scl_out = 1'b0; r.sda_out = 1'b1;       end
         PH_MA_LOW:  begin r.scl_out = 1'b0; r.sda_out = master_ack; end
         PH_MA_HIGH: begin r.scl_out = 1'b1; r.sda_out = master_ack; end
         PH_SP_A:    begin r.scl_out = 1'b0; r.sda_out = 1'b0;       end
         PH_SP_B:    begin r.scl_out = 1'b1; r.sda_out = 1'b0;       end
         default:    begin r.scl_out = 1'b1; r.sda_out = 1'b1;       end
      endcase
      r.busy_res  = (ph != PH_IDLE);
      r.done_res  = finished;
      r.read_data = finished ? rx_value : 16'h0000;
      r.ack_fail  = finished ? timed_out : 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps, fed from the tick queue
   // ---------------------------------------------------------------------------------
   int burst_left    = 0;
   int gap_left      = 0;
   bit sender_steady = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) bus_drive_due.push_back(advance_bus_master(req_payload));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bus_ticks_to_send.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= bus_ticks_to_send.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = sender_steady ? 0 : $urandom_range(0, 7);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: rotating stall pattern, plus one long hold-off while the sender is busy
   // ---------------------------------------------------------------------------------
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_left  = 0;
   int          hold_left     = 0;
   bit          long_hold_done = 1'b0;

   task automatic check_word(rsp_type got);
      rsp_type want;
      string   bad;
      want = bus_drive_due.pop_front();
      bad  = "";
      if (got.scl_out   !== want.scl_out)   bad = {bad, " scl_out"};
      if (got.sda_out   !== want.sda_out)   bad = {bad, " sda_out"};
      if (got.busy_res  !== want.busy_res)  bad = {bad, " busy_res"};
      if (got.done_res  !== want.done_res)  bad = {bad, " done_res"};
      if (got.read_data !== want.read_data) bad = {bad, " read_data"};
      if (got.ack_fail  !== want.ack_fail)  bad = {bad, " ack_fail"};
      if (bad != "") begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("word %0d differs in%s: expected %p, got %p", results_seen, bad, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (bus_drive_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("word %0d arrived unasked: %p", results_seen, rsp_payload);
         end else begin
            check_word(rsp_payload);
         end
         results_seen++;
      end

      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 250 && bus_ticks_to_send.size() > 20) begin
         // hold off long enough for the block to fill and drop req_ready
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left  = $urandom_range(16, 96);
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : ($urandom | 16'h0001);
         end else begin
            pattern_left--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
         rsp_ready <= ready_pattern[0];
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   task automatic push_tick(logic [1:0] mode, logic [7:0] ra, logic [15:0] wd, logic sda);
      req_type t;
      t.mode       = mode;
      t.target_reg = ra;
      t.write_data = wd;
      t.sda_in     = sda;
      bus_ticks_to_send.push_back(t);
   endtask

   // high_eighths sets how often the slave leaves the data line high
   task automatic push_random_ticks(int n, int high_eighths);
      for (int i = 0; i < n; i++)
         push_tick(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                   $urandom_range(0, 7) < high_eighths);
   endtask

   // wait until every queued word has been sent and every result it caused has come back
   task automatic drain();
      do @(negedge clock);
      while (bus_ticks_to_send.size() != 0 || req_valid || bus_drive_due.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DEV_ADDR:    cfg_dev       = val[DEV_ADDR_W-1:0];
         CSR_HALF_PERIOD: cfg_half      = val;
         CSR_ACK_TIMEOUT: cfg_ack_limit = val;
         default: ;
      endcase
   endtask

   initial begin
      logic [15:0] hp;
      logic [15:0] limit;
      logic [6:0]  dev;
      clear_bus_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      push_tick(MODE_UNUSED, 8'hff, 16'hffff, 1'b1);   // reserved mode does nothing
      push_tick(MODE_NONE,   8'hff, 16'hffff, 1'b0);
      push_tick(MODE_WRITE,  8'h00, 16'h0000, 1'b1);
      push_tick(MODE_READ,   8'hff, 16'hffff, 1'b0);   // dropped while busy
      push_tick(MODE_WRITE,  8'h5a, 16'ha5c3, 1'b1);
      drain();

      // stretch the running step to the longest, then collapse it mid-transaction
      write_csr(CSR_HALF_PERIOD, 16'hffff);
      push_tick(MODE_READ, 8'h81, 16'h7e01, 1'b0);
      push_tick(MODE_NONE, 8'h00, 16'h0000, 1'b1);
      push_tick(MODE_WRITE, 8'hc3, 16'h8000, 1'b0);
      drain();
      write_csr(CSR_HALF_PERIOD, 16'h0000);
      write_csr(CSR_DEV_ADDR, 16'h007f);
      write_csr(CSR_ACK_TIMEOUT, 16'h0000);
      push_random_ticks(60, 4);
      drain();

      for (int phase_no = 0; phase_no < 8; phase_no++) begin
         case ($urandom_range(0, 3))
            0: dev = 7'h00;
            1: dev = 7'h7f;
            default: dev = 7'($urandom_range(0, 127));
         endcase
         case ($urandom_range(0, 7))
            0: hp = 16'd0;
            6: hp = 16'd2;
            7: hp = 16'd3;
            default: hp = 16'd1;
         endcase
         case ($urandom_range(0, 5))
            0: limit = 16'd0;
            1: limit = 16'd1;
            2: limit = 16'd3;
            3: limit = 16'd250;
            4: limit = 16'hffff;
            default: limit = 16'($urandom_range(1, 20));
         endcase
         write_csr(CSR_DEV_ADDR, {9'd0, dev});
         write_csr(CSR_HALF_PERIOD, hp);
         write_csr(CSR_ACK_TIMEOUT, limit);
         @(negedge clock);
         sender_steady = ($urandom_range(0, 3) == 0);
         push_random_ticks(75, $urandom_range(2, 6));
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && bus_drive_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
